### hw/rtl/rtt_estimator_rto_backoff_defines.svh
// Assertion macros for the round-trip timer RTL.
`ifndef RTT_ESTIMATOR_RTO_BACKOFF_DEFINES_SVH
`define RTT_ESTIMATOR_RTO_BACKOFF_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define RTTRB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define RTTRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rttrb_pkg.sv
// Shared constants, codes and types for the round-trip timer.
`default_nettype none

package rttrb_pkg;

    // Field and register widths
    localparam int unsigned CFG_W       = 26;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned SEQ_W       = 24;
    localparam int unsigned DELAY_W     = 16;
    localparam int unsigned CFG_ADDR_W  = 2;

    // Sequence compare width and backoff limit
    localparam int unsigned SEQ_BITS    = 24;
    localparam int unsigned BACKOFF_MAX = 255;
    localparam int unsigned BACKOFF_W   = $clog2(BACKOFF_MAX + 1);

    // Milliseconds to microseconds: 16-bit delay times 1000 fits in 26 bits
    localparam int unsigned US_PER_MS_W = 10;
    localparam int unsigned HOLD_W      = DELAY_W + US_PER_MS_W;
    localparam logic [US_PER_MS_W-1:0] US_PER_MS = 10'd1000;

    // Register reset values
    localparam logic [CFG_W-1:0] INITIAL_RTO_RST = 26'd1000000;
    localparam logic [CFG_W-1:0] TICK_TIME_RST   = 26'd10000;
    localparam logic [CFG_W-1:0] MIN_RTO_RST     = 26'd200000;
    localparam logic [CFG_W-1:0] MAX_RTO_RST     = 26'd60000000;

    // NAK interval before the first RTT sample
    localparam logic [TIME_W-1:0] NAK_DEFAULT = 32'd1000000;

    // Event codes
    typedef enum logic [1:0] {
        REQ_PACKET      = 2'd0,
        REQ_TIMEOUT     = 2'd1,
        REQ_OPPORTUNITY = 2'd2
    } req_type_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INITIAL_RTO = 2'd0,
        CFG_TICK_TIME   = 2'd1,
        CFG_MIN_RTO     = 2'd2,
        CFG_MAX_RTO     = 2'd3
    } cfg_idx_t;

    // One RTT sample handed to the estimator
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] rtt;
    } sample_t;

    // Estimator state
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] smoothed_rtt;
        logic [TIME_W-1:0] rtt_variance;
        logic [TIME_W-1:0] base_rto;
    } est_t;

    // Everything the timeout and NAK computation looks at
    typedef struct packed {
        est_t                 est;
        logic [BACKOFF_W-1:0] backoff;
        logic [CFG_W-1:0]     tick_time;
        logic [CFG_W-1:0]     min_rto;
        logic [CFG_W-1:0]     max_rto;
    } timer_state_t;

endpackage

`default_nettype wire

### hw/rtl/rttrb_estimator.sv
// Smoothed RTT and variance estimator with base RTO register.
`default_nettype none

module rttrb_estimator (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rttrb_pkg::sample_t        sample,
    input  wire logic                      init_we,
    input  wire logic [rttrb_pkg::CFG_W-1:0] init_value,
    output rttrb_pkg::est_t                est
);
    import rttrb_pkg::*;

    localparam int unsigned ACC_W = TIME_W + 3;

    logic              valid_reg, valid_next;
    logic [TIME_W-1:0] srtt_reg, srtt_next;
    logic [TIME_W-1:0] var_reg, var_next;
    logic [TIME_W-1:0] base_reg, base_next;

    logic [ACC_W-1:0]  srtt_acc;
    logic [ACC_W-1:0]  var_acc;
    logic [ACC_W-1:0]  base_sum;
    logic [TIME_W-1:0] srtt_upd;
    logic [TIME_W-1:0] diff;

    // Fold a sample into the running averages with gain one eighth
    always_comb
    begin
        srtt_acc = (ACC_W'(srtt_reg) << 3) - ACC_W'(srtt_reg) + ACC_W'(sample.rtt);
        srtt_upd = srtt_acc[ACC_W-1:3];
        diff     = (srtt_upd >= sample.rtt) ? (srtt_upd - sample.rtt)
                                            : (sample.rtt - srtt_upd);
        var_acc  = (ACC_W'(var_reg) << 3) - ACC_W'(var_reg) + ACC_W'(diff);

        valid_next = valid_reg;
        srtt_next  = srtt_reg;
        var_next   = var_reg;
        base_next  = base_reg;

        if (sample.valid)
        begin
            valid_next = 1'b1;
            if (!valid_reg)
            begin
                srtt_next = sample.rtt;
                var_next  = sample.rtt >> 1;
            end
            else
            begin
                srtt_next = srtt_upd;
                var_next  = var_acc[ACC_W-1:3];
            end
        end

        // Base RTO is smoothed RTT plus four variances, saturated
        base_sum = ACC_W'(srtt_next) + {1'b0, var_next, 2'b00};

        if (sample.valid)
        begin
            base_next = (|base_sum[ACC_W-1:TIME_W]) ? '1 : base_sum[TIME_W-1:0];
        end
        else if (init_we && !valid_reg)
        begin
            base_next = TIME_W'(init_value);
        end
    end

    // Hold estimator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            srtt_reg  <= '0;
            var_reg   <= '0;
            base_reg  <= TIME_W'(INITIAL_RTO_RST);
        end
        else
        begin
            valid_reg <= valid_next;
            srtt_reg  <= srtt_next;
            var_reg   <= var_next;
            base_reg  <= base_next;
        end
    end

    assign est.valid        = valid_reg;
    assign est.smoothed_rtt = srtt_reg;
    assign est.rtt_variance = var_reg;
    assign est.base_rto     = base_reg;

endmodule

`default_nettype wire

### hw/rtl/rttrb_rto_calc.sv
// Backed-off, clamped RTO and NAK interval from the current timer state.
`default_nettype none

module rttrb_rto_calc (
    input  wire rttrb_pkg::timer_state_t       st,
    output logic [rttrb_pkg::CFG_W-1:0]        rto,
    output logic [rttrb_pkg::TIME_W-1:0]       nak
);
    import rttrb_pkg::*;

    localparam int unsigned MULT_W = BACKOFF_W + 1;
    localparam int unsigned PROD_W = TIME_W + MULT_W;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned NAK_W  = TIME_W + 3;

    logic [MULT_W-1:0] factor;
    logic [SUM_W-1:0]  r_sum;
    logic [SUM_W-1:0]  r_lo;
    logic [SUM_W-1:0]  r_hi;
    logic [NAK_W-1:0]  nak_sum;

    // Scale base RTO by backoff plus one, add a tick, clamp to min then max
    always_comb
    begin
        factor = {1'b0, st.backoff} + MULT_W'(1);
        r_sum  = SUM_W'(PROD_W'(st.est.base_rto) * PROD_W'(factor)) + SUM_W'(st.tick_time);
        r_lo   = (r_sum < SUM_W'(st.min_rto)) ? SUM_W'(st.min_rto) : r_sum;
        r_hi   = (r_lo > SUM_W'(st.max_rto)) ? SUM_W'(st.max_rto) : r_lo;
        rto    = r_hi[CFG_W-1:0];
    end

    // NAK interval: four smoothed RTTs plus variance plus a tick, saturated; the default before the first sample
    always_comb
    begin
        nak_sum = {1'b0, st.est.smoothed_rtt, 2'b00} + NAK_W'(st.est.rtt_variance)
                + NAK_W'(st.tick_time);
        if (!st.est.valid)
        begin
            nak = NAK_DEFAULT;
        end
        else
        begin
            nak = (|nak_sum[NAK_W-1:TIME_W]) ? '1 : nak_sum[TIME_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rtt_estimator_rto_backoff.sv
// A result word passes from the input stage through the result stage into the output register.
// Throughput: one word per cycle unless out_ready stalls; the state update and RTO multiply each take one stage.
// The event stage reads the timeout for its grant from the same state the result stage reads.
// Reset clears the pipeline, the estimator and the backoff and loads the register defaults.
`default_nettype none
`include "rtt_estimator_rto_backoff_defines.svh"

module rtt_estimator_rto_backoff (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [rttrb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [rttrb_pkg::CFG_W-1:0]     cfg_wdata,
    // Event channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      req_type,
    input  wire logic [rttrb_pkg::TIME_W-1:0]    now,
    input  wire logic                            has_rtt_response,
    input  wire logic [rttrb_pkg::SEQ_W-1:0]     response_seq,
    input  wire logic [rttrb_pkg::DELAY_W-1:0]   response_delay_ms,
    input  wire logic [rttrb_pkg::SEQ_W-1:0]     request_seq,
    // Result channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [rttrb_pkg::CFG_W-1:0]          rto_out,
    output logic [rttrb_pkg::TIME_W-1:0]         nak_interval,
    output logic                                 request_granted
);
    import rttrb_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] tick_reg, min_rto_reg, max_rto_reg;

    // Input stage
    logic                a_valid_reg, a_valid_next;
    logic [1:0]          type_reg;
    logic [TIME_W-1:0]   now_reg;
    logic                has_resp_reg;
    logic [SEQ_BITS-1:0] resp_seq_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic [SEQ_BITS-1:0] req_seq_reg;

    // Result stage and output register
    logic                b_valid_reg, b_valid_next;
    logic                b_granted_reg;
    logic                out_valid_reg, out_valid_next;
    logic [CFG_W-1:0]    rto_reg;
    logic [TIME_W-1:0]   nak_reg;
    logic                granted_reg;

    // Connection state
    logic [BACKOFF_W-1:0] backoff_reg, backoff_next;
    logic                 pending_reg, pending_next;
    logic [SEQ_BITS-1:0]  pending_seq_reg;
    logic [TIME_W-1:0]    req_time_reg;

    logic              out_go, a_go, a_fire, in_fire;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] hold_us;
    logic              resp_match;
    logic              grant;
    sample_t           sample;
    est_t              est;
    timer_state_t      st;
    logic [CFG_W-1:0]  rto_cur;
    logic [TIME_W-1:0] nak_cur;

    // Flow control: a stage moves when the stage after it is empty or moves; the output word when it is empty or taken
    assign out_go   = !out_valid_reg || out_ready;
    assign a_go     = !b_valid_reg || out_go;
    assign a_fire   = a_valid_reg && a_go;
    assign in_ready = !a_valid_reg || a_go;
    assign in_fire  = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg    <= TICK_TIME_RST;
            min_rto_reg <= MIN_RTO_RST;
            max_rto_reg <= MAX_RTO_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_TICK_TIME: tick_reg    <= cfg_wdata;
                CFG_MIN_RTO:   min_rto_reg <= cfg_wdata;
                CFG_MAX_RTO:   max_rto_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // Estimator
    rttrb_estimator u_estimator (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .init_we    (cfg_wr_en && (cfg_addr == CFG_INITIAL_RTO)),
        .init_value (cfg_wdata),
        .est        (est)
    );

    // Current timeout, shared by grant check and result stage, and NAK interval for the result stage
    always_comb
    begin
        st.est       = est;
        st.backoff   = backoff_reg;
        st.tick_time = tick_reg;
        st.min_rto   = min_rto_reg;
        st.max_rto   = max_rto_reg;
    end

    rttrb_rto_calc u_rto_calc (
        .st  (st),
        .rto (rto_cur),
        .nak (nak_cur)
    );

    // Event stage: sample, grant and backoff decisions
    always_comb
    begin
        elapsed    = now_reg - req_time_reg;
        hold_us    = TIME_W'(hold_reg);
        resp_match = has_resp_reg && pending_reg && (resp_seq_reg == pending_seq_reg);

        sample.valid = a_fire && (type_reg == REQ_PACKET) && resp_match;
        sample.rtt   = (elapsed > hold_us) ? (elapsed - hold_us) : '0;

        grant = (type_reg == REQ_OPPORTUNITY) &&
                (!pending_reg ||
                 ((elapsed > TIME_W'(rto_cur)) && (elapsed > TIME_W'(tick_reg))));

        backoff_next = backoff_reg;
        pending_next = pending_reg;
        if (a_fire)
        begin
            case (type_reg)
                REQ_PACKET:
                begin
                    backoff_next = '0;
                end
                REQ_TIMEOUT:
                begin
                    if (backoff_reg < BACKOFF_W'(BACKOFF_MAX))
                    begin
                        backoff_next = backoff_reg + BACKOFF_W'(1);
                    end
                end
                REQ_OPPORTUNITY:
                begin
                    if (grant)
                    begin
                        pending_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Stage occupancy
    always_comb
    begin
        a_valid_next   = in_fire ? 1'b1 : (a_go ? 1'b0 : a_valid_reg);
        b_valid_next   = a_fire ? 1'b1 : (out_go ? 1'b0 : b_valid_reg);
        out_valid_next = out_go ? b_valid_reg : out_valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            backoff_reg     <= '0;
            pending_reg     <= 1'b0;
            pending_seq_reg <= '0;
            req_time_reg    <= '0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            backoff_reg   <= backoff_next;
            pending_reg   <= pending_next;
            if (a_fire && grant)
            begin
                pending_seq_reg <= req_seq_reg;
                req_time_reg    <= now_reg;
            end
        end
    end

    // Capture the input word; convert the peer hold delay to microseconds
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            type_reg     <= req_type;
            now_reg      <= now;
            has_resp_reg <= has_rtt_response;
            resp_seq_reg <= SEQ_BITS'(response_seq);
            hold_reg     <= HOLD_W'(response_delay_ms) * HOLD_W'(US_PER_MS);
            req_seq_reg  <= SEQ_BITS'(request_seq);
        end
    end

    // Advance the grant flag and load the result word
    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_granted_reg <= (type_reg == REQ_OPPORTUNITY) && grant;
        end
        if (out_go && b_valid_reg)
        begin
            rto_reg     <= rto_cur;
            nak_reg     <= nak_cur;
            granted_reg <= b_granted_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign rto_out         = rto_reg;
    assign nak_interval    = nak_reg;
    assign request_granted = granted_reg;

    // A granted result always leaves a pending request behind
    `RTTRB_ASSERT_ALWAYS(a_grant_pending, !(out_valid && request_granted) || pending_reg, "granted word without pending request")
    // Backoff never passes its limit
    `RTTRB_ASSERT_ALWAYS(a_backoff_limit, backoff_reg <= BACKOFF_W'(BACKOFF_MAX), "backoff count above limit")
    // A stalled event stage keeps its word
    `RTTRB_ASSERT_NEXT(a_event_hold, a_valid_reg && !a_go, a_valid_reg, "event word lost while stalled")

endmodule

`default_nettype wire
